@@ rtl/braille_cell_color_grader_defines.svh @@
// Assertion helpers for the braille cell grader checks.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef BRAILLE_CELL_COLOR_GRADER_DEFINES_SVH
`define BRAILLE_CELL_COLOR_GRADER_DEFINES_SVH

// Same-cycle implication.
`define BCCG_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define BCCG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/bccg_pkg.sv @@
`timescale 1ns / 1ps
package bccg_pkg;

	localparam int GT_BITS = 10;
	localparam int GT_SIZE = 1 << GT_BITS;
	localparam int GT_SHIFT = 59 * GT_BITS - 50;
	localparam int BN_W = 59 * GT_BITS + 460;

	localparam int CH_W = 17;
	localparam int SUM_W = 20;
	localparam int ACC_W = 35;
	localparam int PROD_W = 34;

	localparam logic [CH_W-1:0] LUMA_R = 17'd19595;
	localparam logic [CH_W-1:0] LUMA_G = 17'd38470;
	localparam logic [CH_W-1:0] LUMA_B = 17'd7471;
	localparam logic [CH_W-1:0] Q_ONE = 17'h10000;

	localparam logic REG_THRESHOLD = 1'b0;
	localparam logic REG_BLUE_GAIN = 1'b1;

	localparam logic [16:0] THRESHOLD_RST = 17'd32768;
	localparam logic [15:0] BLUE_GAIN_RST = 16'd2621;

	typedef logic [7:0] gamma_lut_t [GT_SIZE];

	// T[i] counts the k in 0..254 with (2k+1)^50 * 2^GT_SHIFT <= 255^50 * i^59,
	// which is round-half-up of 255 * (i / GT_SIZE)^1.18 done exactly.
	function automatic gamma_lut_t build_gamma();
		gamma_lut_t lut;
		logic [BN_W-1:0] lhs;
		logic [BN_W-1:0] rhs;
		int k;
		bit done;
		k = 0;
		for (int i = 0; i < GT_SIZE; i++) begin
			rhs = BN_W'(1);
			for (int j = 0; j < 50; j++) rhs = rhs * BN_W'(255);
			for (int j = 0; j < 59; j++) rhs = rhs * BN_W'(i);
			done = 1'b0;
			while (!done && k < 255) begin
				lhs = BN_W'(1);
				for (int j = 0; j < 50; j++) lhs = lhs * BN_W'(2 * k + 1);
				lhs = lhs << GT_SHIFT;
				if (lhs <= rhs) k = k + 1;
				else done = 1'b1;
			end
			lut[i] = 8'(k);
		end
		return lut;
	endfunction

	localparam gamma_lut_t GAMMA_LUT = build_gamma();

	function automatic logic [7:0] gamma_byte(input logic [CH_W-1:0] v);
		logic [7:0] res;
		if (v == '0) res = 8'd0;
		else if (v[CH_W-1]) res = 8'd255;
		else res = GAMMA_LUT[v[15 -: GT_BITS]];
		return res;
	endfunction

	// Row-major position to braille dot bit.
	function automatic logic [2:0] dot_bit(input logic [2:0] pos);
		logic [2:0] res;
		unique case (pos)
			3'd0: res = 3'd0;
			3'd1: res = 3'd3;
			3'd2: res = 3'd1;
			3'd3: res = 3'd4;
			3'd4: res = 3'd2;
			3'd5: res = 3'd5;
			3'd6: res = 3'd6;
			default: res = 3'd7;
		endcase
		return res;
	endfunction

endpackage

@@ rtl/bccg_pix_if.sv @@
`timescale 1ns / 1ps
interface bccg_pix_if;
	import bccg_pkg::*;
	logic valid;
	logic ready;
	logic [CH_W-1:0] red;
	logic [CH_W-1:0] green;
	logic [CH_W-1:0] blue;
	logic frame_start;
	modport source(output valid, red, green, blue, frame_start, input ready);
	modport sink(input valid, red, green, blue, frame_start, output ready);
endinterface

@@ rtl/bccg_cell_if.sv @@
`timescale 1ns / 1ps
interface bccg_cell_if;
	logic valid;
	logic ready;
	logic lit;
	logic [7:0] dot_mask;
	logic [7:0] red_byte;
	logic [7:0] green_byte;
	logic [7:0] blue_byte;
	logic colour_changed;
	modport source(output valid, lit, dot_mask, red_byte, green_byte, blue_byte,
		colour_changed, input ready);
	modport sink(input valid, lit, dot_mask, red_byte, green_byte, blue_byte,
		colour_changed, output ready);
endinterface

@@ rtl/braille_cell_color_grader.sv @@
`timescale 1ns / 1ps
// Braille cell colour grader: takes RGB sub-pixels in Q1.16, eight per 2x4 cell
// in row-major order, and after the eighth returns one item with the dot mask and
// the gamma-corrected mean colour of the lit dots, with blue shadow-lifted. All
// multiplies run through one shared 17x17 multiplier and the divisions through
// a one-bit-per-cycle divider under a small sequencer. A sub-pixel occupies the
// block through the accepting cycle, three multiply and accumulate pairs for
// luma, and the threshold test. The eighth sub-pixel of a cell with any lit dot
// goes on to three serial divisions for the means, the luma of the means, three
// chained multiplies for the blue lift, three gamma table reads and the emit. A
// blank cell goes straight from the cell state to the emit. The emit also waits
// for as long as the previous item still sits unaccepted in the output register.
// Once emitted, the item waits there and the next sub-pixel is taken meanwhile.
// Registers: luma threshold at byte 0, shadow_blue_gain at byte 4.
module braille_cell_color_grader (
	input  logic clk,
	input  logic arst_n,
	bccg_pix_if.sink pix,
	bccg_cell_if.source dots,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [2:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import bccg_pkg::*;

	typedef enum logic [12:0] {
		S_IDLE  = 13'b0000000000001,
		S_LMUL  = 13'b0000000000010,
		S_LACC  = 13'b0000000000100,
		S_TEST  = 13'b0000000001000,
		S_CELL  = 13'b0000000010000,
		S_DIV   = 13'b0000000100000,
		S_SHADE = 13'b0000001000000,
		S_SQ    = 13'b0000010000000,
		S_TMUL  = 13'b0000100000000,
		S_LIFT  = 13'b0001000000000,
		S_ADD   = 13'b0010000000000,
		S_GAMMA = 13'b0100000000000,
		S_EMIT  = 13'b1000000000000
	} state_t;

	state_t state_q;
	logic [1:0] idx_q;
	logic fin_q;
	logic [CH_W-1:0] r_q, g_q, b_q;
	logic [ACC_W-1:0] acc_q;
	logic [PROD_W-1:0] prod_q;
	logic [2:0] pos_q;
	logic [7:0] mask_q;
	logic [SUM_W-1:0] rsum_q, gsum_q, bsum_q;
	logic [3:0] cnt_q;
	logic [CH_W-1:0] mr_q, mg_q, mb_q;
	logic [CH_W-1:0] shadow_q;
	logic [SUM_W-1:0] div_q;
	logic [3:0] rem_q;
	logic [4:0] bit_q;
	logic [23:0] prev_q;
	logic prev_valid_q;
	logic [16:0] thr_q;
	logic [15:0] gain_q;
	logic [7:0] gr_q, gg_q, gb_q;
	logic out_valid_q;
	logic out_lit_q;
	logic [7:0] out_mask_q, out_r_q, out_g_q, out_b_q;
	logic out_changed_q;

	logic [CH_W-1:0] mul_a, mul_b, chan;
	logic [PROD_W-1:0] prod;
	logic in_fire, cfg_wr, px_lit, div_ge, emit_fire, blank, changed;
	logic [4:0] trial;
	logic [3:0] rem_d;
	logic [SUM_W-1:0] quot;
	logic [18:0] lum;
	logic [7:0] gamma_rd;
	logic [7:0] gr, gg, gb;
	logic [23:0] colour;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_BLUE_GAIN) ? {16'd0, gain_q} : {15'd0, thr_q};

	assign pix.ready = (state_q == S_IDLE);
	assign in_fire = pix.valid && pix.ready;

	assign dots.valid = out_valid_q;
	assign dots.lit = out_lit_q;
	assign dots.dot_mask = out_mask_q;
	assign dots.red_byte = out_r_q;
	assign dots.green_byte = out_g_q;
	assign dots.blue_byte = out_b_q;
	assign dots.colour_changed = out_changed_q;

	// Shared multiplier operand select.
	always_comb begin
		unique case (idx_q)
			2'd0: chan = fin_q ? mr_q : r_q;
			2'd1: chan = fin_q ? mg_q : g_q;
			default: chan = fin_q ? mb_q : b_q;
		endcase
		mul_a = '0;
		mul_b = '0;
		if (state_q == S_LMUL) begin
			mul_a = chan;
			unique case (idx_q)
				2'd0: mul_b = LUMA_R;
				2'd1: mul_b = LUMA_G;
				default: mul_b = LUMA_B;
			endcase
		end else if (state_q == S_SQ) begin
			mul_a = shadow_q;
			mul_b = shadow_q;
		end else if (state_q == S_TMUL) begin
			mul_a = prod_q[32:16];
			mul_b = {1'b0, gain_q};
		end else if (state_q == S_LIFT) begin
			mul_a = Q_ONE - mb_q;
			mul_b = {1'b0, prod_q[31:16]};
		end
	end

	assign prod = {17'd0, mul_a} * {17'd0, mul_b};
	assign px_lit = acc_q > ACC_W'({thr_q, 16'h0000});

	assign trial = {rem_q, div_q[SUM_W-1]};
	assign div_ge = trial >= {1'b0, cnt_q};
	assign rem_d = div_ge ? 4'(trial - {1'b0, cnt_q}) : trial[3:0];
	assign quot = {div_q[SUM_W-2:0], div_ge};

	assign lum = acc_q[34:16];

	// One gamma table read per cycle, one channel after the other.
	assign gamma_rd = gamma_byte(chan);

	assign blank = (cnt_q == 4'd0);
	assign gr = blank ? 8'd0 : gr_q;
	assign gg = blank ? 8'd0 : gg_q;
	assign gb = blank ? 8'd0 : gb_q;
	assign colour = {gr, gg, gb};
	assign changed = !blank && (!prev_valid_q || colour != prev_q);
	assign emit_fire = (state_q == S_EMIT) && (!out_valid_q || dots.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THRESHOLD_RST;
			gain_q <= BLUE_GAIN_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_THRESHOLD) thr_q <= pwdata[16:0];
			else gain_q <= pwdata[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (dots.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			out_lit_q <= !blank;
			out_mask_q <= mask_q;
			out_r_q <= gr;
			out_g_q <= gg;
			out_b_q <= gb;
			out_changed_q <= changed;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q <= '0;
			fin_q <= 1'b0;
			pos_q <= '0;
			mask_q <= '0;
			rsum_q <= '0;
			gsum_q <= '0;
			bsum_q <= '0;
			cnt_q <= '0;
			prev_q <= '0;
			prev_valid_q <= 1'b0;
			bit_q <= '0;
			rem_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						idx_q <= '0;
						fin_q <= 1'b0;
						state_q <= S_LMUL;
						if (pix.frame_start) begin
							pos_q <= '0;
							mask_q <= '0;
							rsum_q <= '0;
							gsum_q <= '0;
							bsum_q <= '0;
							cnt_q <= '0;
							prev_q <= '0;
							prev_valid_q <= 1'b0;
						end
					end
				end
				S_LMUL: state_q <= S_LACC;
				S_LACC: begin
					if (idx_q == 2'd2) begin
						idx_q <= '0;
						state_q <= fin_q ? S_SHADE : S_TEST;
					end else begin
						idx_q <= idx_q + 2'd1;
						state_q <= S_LMUL;
					end
				end
				S_TEST: begin
					if (px_lit) begin
						mask_q <= mask_q | (8'd1 << dot_bit(pos_q));
						rsum_q <= rsum_q + SUM_W'(r_q);
						gsum_q <= gsum_q + SUM_W'(g_q);
						bsum_q <= bsum_q + SUM_W'(b_q);
						cnt_q <= cnt_q + 4'd1;
					end
					if (pos_q != 3'd7) begin
						pos_q <= pos_q + 3'd1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_CELL;
					end
				end
				S_CELL: begin
					idx_q <= '0;
					bit_q <= '0;
					rem_q <= '0;
					state_q <= blank ? S_EMIT : S_DIV;
				end
				S_DIV: begin
					if (bit_q == 5'(SUM_W - 1)) begin
						rem_q <= '0;
						bit_q <= '0;
						if (idx_q == 2'd2) begin
							idx_q <= '0;
							fin_q <= 1'b1;
							state_q <= S_LMUL;
						end else begin
							idx_q <= idx_q + 2'd1;
						end
					end else begin
						rem_q <= rem_d;
						bit_q <= bit_q + 5'd1;
					end
				end
				S_SHADE: state_q <= S_SQ;
				S_SQ: state_q <= S_TMUL;
				S_TMUL: state_q <= S_LIFT;
				S_LIFT: state_q <= S_ADD;
				S_ADD: state_q <= S_GAMMA;
				S_GAMMA: begin
					if (idx_q == 2'd2) begin
						idx_q <= '0;
						state_q <= S_EMIT;
					end else begin
						idx_q <= idx_q + 2'd1;
					end
				end
				S_EMIT: begin
					if (emit_fire) begin
						if (!blank) begin
							prev_q <= colour;
							prev_valid_q <= 1'b1;
						end
						pos_q <= '0;
						mask_q <= '0;
						rsum_q <= '0;
						gsum_q <= '0;
						bsum_q <= '0;
						cnt_q <= '0;
						fin_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			r_q <= pix.red;
			g_q <= pix.green;
			b_q <= pix.blue;
			acc_q <= '0;
		end
		if (state_q == S_LMUL || state_q == S_SQ || state_q == S_TMUL
			|| state_q == S_LIFT) begin
			prod_q <= prod;
		end
		if (state_q == S_LACC) acc_q <= acc_q + ACC_W'(prod_q);
		if (state_q == S_CELL) div_q <= rsum_q;
		if (state_q == S_DIV) begin
			if (bit_q == 5'(SUM_W - 1)) begin
				unique case (idx_q)
					2'd0: begin
						mr_q <= quot[CH_W-1:0];
						div_q <= gsum_q;
					end
					2'd1: begin
						mg_q <= quot[CH_W-1:0];
						div_q <= bsum_q;
					end
					default: begin
						mb_q <= quot[CH_W-1:0];
						acc_q <= '0;
					end
				endcase
			end else begin
				div_q <= quot;
			end
		end
		if (state_q == S_SHADE) begin
			shadow_q <= (lum >= 19'h10000) ? '0 : CH_W'(19'h10000 - lum);
		end
		// Lift applies only while the mean blue is below one.
		if (state_q == S_ADD && !mb_q[CH_W-1]) begin
			mb_q <= mb_q + {1'b0, prod_q[31:16]};
		end
		if (state_q == S_GAMMA) begin
			unique case (idx_q)
				2'd0: gr_q <= gamma_rd;
				2'd1: gg_q <= gamma_rd;
				default: gb_q <= gamma_rd;
			endcase
		end
	end

endmodule

@@ rtl/bccg_checker.sv @@
`timescale 1ns / 1ps
`include "braille_cell_color_grader_defines.svh"
module bccg_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic lit,
	input logic [7:0] dot_mask,
	input logic [7:0] red_byte,
	input logic [7:0] green_byte,
	input logic [7:0] blue_byte,
	input logic colour_changed
);
	// Taking a sub-pixel moves the sequencer out of idle, so the input closes right after an item.
	`BCCG_ASSERT_NEXT(a_busy_after_item, in_valid && in_ready, !in_ready, "ready after item")
	`BCCG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(dot_mask) && $stable(red_byte) && $stable(blue_byte), "stalled result changed")
	`BCCG_ASSERT(a_blank_zero, out_valid && !lit, dot_mask == 8'd0 && red_byte == 8'd0 && green_byte == 8'd0 && blue_byte == 8'd0 && !colour_changed, "blank cell not zero")
	`BCCG_ASSERT(a_lit_has_dot, out_valid && lit, dot_mask != 8'd0, "lit cell without dots")
endmodule

bind braille_cell_color_grader bccg_checker u_bccg_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(pix.valid),
	.in_ready(pix.ready),
	.out_valid(dots.valid),
	.out_ready(dots.ready),
	.lit(dots.lit),
	.dot_mask(dots.dot_mask),
	.red_byte(dots.red_byte),
	.green_byte(dots.green_byte),
	.blue_byte(dots.blue_byte),
	.colour_changed(dots.colour_changed)
);

@@ verif/braille_cell_color_grader_test.sv @@
`timescale 1ns / 1ps
module braille_cell_color_grader_test;
	import bccg_pkg::*;

	localparam logic [2:0] ADDR_THRESHOLD = 3'd0;
	localparam logic [2:0] ADDR_BLUE_GAIN = 3'd4;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int HOLD_CYCLES = 600;
	localparam int SETTLE_CYCLES = 150;
	localparam int NUM_W = 1100;

	typedef struct {
		logic [16:0] red;
		logic [16:0] green;
		logic [16:0] blue;
		logic frame_start;
	} subpixel_t;

	typedef struct {
		logic lit;
		logic [7:0] dot_mask;
		logic [7:0] red_byte;
		logic [7:0] green_byte;
		logic [7:0] blue_byte;
		logic colour_changed;
	} cell_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	bccg_pix_if pix ();
	bccg_cell_if dots ();

	braille_cell_color_grader DUT (
		.clk(clk),
		.arst_n(arst_n),
		.pix(pix.sink),
		.dots(dots.source),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Grader model state.
	logic [16:0] cur_threshold;
	logic [15:0] cur_blue_gain;
	int unsigned cell_pos;
	logic [7:0] cell_mask;
	longint unsigned sum_r, sum_g, sum_b;
	int unsigned lit_dots;
	logic [23:0] last_colour;
	bit last_colour_valid;
	logic [7:0] gamma_lut [1024];
	const int unsigned dot_of_pos [8] = '{0, 3, 1, 4, 2, 5, 6, 7};

	subpixel_t pending_pix [$];
	cell_t expected_cells [$];
	int errors = 0;
	int cells_seen = 0;
	int lit_cells_seen = 0;
	int pix_sent = 0;
	int idle_cycles = 0;
	bit no_idle = 1'b0;
	bit hold_go = 1'b0;
	bit hold_done = 1'b0;
	int hold_left = 0;
	int tx_gap = 0;
	int rx_gap = 0;

	// Exact round-half-up of 255 * (i/1024)^1.18, built by comparing
	// (2k+1)^50 * 2^540 against 255^50 * i^59.
	task automatic make_gamma_lut();
		logic [NUM_W-1:0] p255, lhs, rhs;
		int k;
		p255 = NUM_W'(1);
		for (int j = 0; j < 50; j++) p255 = p255 * NUM_W'(255);
		k = 0;
		for (int i = 0; i < 1024; i++) begin
			rhs = p255;
			for (int j = 0; j < 59; j++) rhs = rhs * NUM_W'(i);
			while (k < 255) begin
				lhs = NUM_W'(1);
				for (int j = 0; j < 50; j++) lhs = lhs * NUM_W'(2 * k + 1);
				lhs = lhs << 540;
				if (lhs <= rhs) k++;
				else break;
			end
			gamma_lut[i] = 8'(k);
		end
	endtask

	function automatic logic [7:0] to_gamma(longint unsigned v);
		if (v == 0) return 8'd0;
		if (v >= 65536) return 8'd255;
		return gamma_lut[v >> 6];
	endfunction

	function automatic longint unsigned luma_of(longint unsigned r, longint unsigned g,
			longint unsigned b);
		return 19595 * r + 38470 * g + 7471 * b;
	endfunction

	task automatic clear_cell_model();
		cell_pos = 0;
		cell_mask = '0;
		sum_r = 0;
		sum_g = 0;
		sum_b = 0;
		lit_dots = 0;
	endtask

	task automatic grade_subpixel(subpixel_t sp);
		cell_t res;
		longint unsigned mr, mg, mb, lum, shadow, s2, t;
		logic [23:0] colour;
		if (sp.frame_start) begin
			clear_cell_model();
			last_colour = '0;
			last_colour_valid = 1'b0;
		end
		if (luma_of(sp.red, sp.green, sp.blue) > (longint'(cur_threshold) << 16)) begin
			cell_mask[dot_of_pos[cell_pos]] = 1'b1;
			sum_r += sp.red;
			sum_g += sp.green;
			sum_b += sp.blue;
			lit_dots++;
		end
		if (cell_pos < 7) begin
			cell_pos++;
			return;
		end
		res = '{1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0};
		if (lit_dots != 0) begin
			mr = sum_r / lit_dots;
			mg = sum_g / lit_dots;
			mb = sum_b / lit_dots;
			lum = luma_of(mr, mg, mb) >> 16;
			shadow = (lum >= 65536) ? 0 : 65536 - lum;
			s2 = (shadow * shadow) >> 16;
			t = (longint'(cur_blue_gain) * s2) >> 16;
			if (mb < 65536) mb += ((65536 - mb) * t) >> 16;
			res.lit = 1'b1;
			res.dot_mask = cell_mask;
			res.red_byte = to_gamma(mr);
			res.green_byte = to_gamma(mg);
			res.blue_byte = to_gamma(mb);
			colour = {res.red_byte, res.green_byte, res.blue_byte};
			res.colour_changed = !last_colour_valid || colour != last_colour;
			last_colour = colour;
			last_colour_valid = 1'b1;
		end
		expected_cells.push_back(res);
		clear_cell_model();
	endtask

	function automatic int pick_gap();
		if (no_idle || $urandom_range(0, 9) < 6) return 0;
		if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Sender: hold the item until taken, then offer the next one after a random gap, which may be zero.
	always @(posedge clk) begin
		subpixel_t sp;
		bit busy;
		busy = pix.valid && !pix.ready;
		if (pix.valid && pix.ready) begin
			sp = '{pix.red, pix.green, pix.blue, pix.frame_start};
			grade_subpixel(sp);
			pix_sent++;
		end
		if (arst_n && !busy) begin
			if (tx_gap > 0) begin
				tx_gap <= tx_gap - 1;
				pix.valid <= 1'b0;
			end else if (pending_pix.size() > 0) begin
				sp = pending_pix.pop_front();
				pix.valid <= 1'b1;
				pix.red <= sp.red;
				pix.green <= sp.green;
				pix.blue <= sp.blue;
				pix.frame_start <= sp.frame_start;
				tx_gap <= pick_gap();
			end else begin
				pix.valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off to back the block up.
	always @(posedge clk) begin
		if (!arst_n) begin
			dots.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			dots.ready <= 1'b0;
		end else if (hold_go && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			dots.ready <= 1'b0;
		end else if (rx_gap > 0) begin
			rx_gap <= rx_gap - 1;
			dots.ready <= 1'b0;
		end else begin
			dots.ready <= 1'b1;
			rx_gap <= pick_gap();
		end
	end

	always @(posedge clk) begin
		cell_t exp_cell;
		if (dots.valid && dots.ready) begin
			cells_seen++;
			if (dots.lit) lit_cells_seen++;
			if (expected_cells.size() == 0) begin
				$display("%0t: unexpected cell item mask=%h", $time, dots.dot_mask);
				errors++;
			end else begin
				exp_cell = expected_cells.pop_front();
				if (dots.lit !== exp_cell.lit) begin
					$display("%0t: lit expected %b actual %b", $time, exp_cell.lit, dots.lit);
					errors++;
				end
				if (dots.dot_mask !== exp_cell.dot_mask) begin
					$display("%0t: dot_mask expected %h actual %h", $time,
						exp_cell.dot_mask, dots.dot_mask);
					errors++;
				end
				if (dots.red_byte !== exp_cell.red_byte) begin
					$display("%0t: red_byte expected %h actual %h", $time,
						exp_cell.red_byte, dots.red_byte);
					errors++;
				end
				if (dots.green_byte !== exp_cell.green_byte) begin
					$display("%0t: green_byte expected %h actual %h", $time,
						exp_cell.green_byte, dots.green_byte);
					errors++;
				end
				if (dots.blue_byte !== exp_cell.blue_byte) begin
					$display("%0t: blue_byte expected %h actual %h", $time,
						exp_cell.blue_byte, dots.blue_byte);
					errors++;
				end
				if (dots.colour_changed !== exp_cell.colour_changed) begin
					$display("%0t: colour_changed expected %b actual %b", $time,
						exp_cell.colour_changed, dots.colour_changed);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((pix.valid && pix.ready) || (dots.valid && dots.ready) || psel) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog expired, %0d cells outstanding", $time,
				expected_cells.size());
			$display("braille_cell_color_grader_test: errors");
			$finish;
		end
	end

	task automatic write_reg(logic [2:0] addr, logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_THRESHOLD) cur_threshold = data[16:0];
		else if (addr == ADDR_BLUE_GAIN) cur_blue_gain = data[15:0];
	endtask

	// Checked between edges so that the sender's updates have settled.
	task automatic drain();
		while (pending_pix.size() > 0 || pix.valid || expected_cells.size() > 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic push_px(int r, int g, int b, bit fs);
		subpixel_t sp;
		sp = '{17'(r), 17'(g), 17'(b), fs};
		pending_pix.push_back(sp);
	endtask

	function automatic logic [16:0] rand_channel();
		case ($urandom_range(0, 3))
			0: return 17'($urandom);
			1: return 17'($urandom_range(0, 65535));
			2: return 17'($urandom_range(0, 8000));
			default: return 17'($urandom_range(50000, 131071));
		endcase
	endfunction

	task automatic push_random_cells(int count);
		subpixel_t sp;
		bit flat;
		for (int c = 0; c < count; c++) begin
			// Flat cells repeat one colour, so their dots are all lit or all dark.
			flat = ($urandom_range(0, 5) == 0);
			sp = '{rand_channel(), rand_channel(), rand_channel(), 1'b0};
			for (int p = 0; p < 8; p++) begin
				if (!flat) sp = '{rand_channel(), rand_channel(), rand_channel(), 1'b0};
				sp.frame_start = (p == 0 && $urandom_range(0, 7) == 0)
					|| ($urandom_range(0, 60) == 0);
				pending_pix.push_back(sp);
			end
		end
	endtask

	initial begin
		pix.valid = 1'b0;
		pix.red = '0;
		pix.green = '0;
		pix.blue = '0;
		pix.frame_start = 1'b0;
		cur_threshold = 17'd32768;
		cur_blue_gain = 16'd2621;
		clear_cell_model();
		last_colour = '0;
		last_colour_valid = 1'b0;
		make_gamma_lut();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: defaults, saturated, blank, half-lit, shadowed blue, repeated colour.
		for (int p = 0; p < 8; p++) push_px(131071, 131071, 131071, p == 0);
		for (int p = 0; p < 8; p++) push_px(0, 0, 0, 1'b0);
		for (int p = 0; p < 8; p++)
			push_px(p[0] ? 0 : 60000, 1000, p[0] ? 0 : 131071, p == 0);
		drain();
		write_reg(ADDR_THRESHOLD, 32'd0);
		write_reg(ADDR_BLUE_GAIN, 32'd65535);
		for (int p = 0; p < 8; p++) push_px(2000, 2000, 30000, p == 0);
		for (int p = 0; p < 8; p++) push_px(2000, 2000, 30000, 1'b0);
		drain();

		write_reg(ADDR_THRESHOLD, 32'd131071);
		write_reg(ADDR_BLUE_GAIN, 32'd0);
		push_random_cells(8);
		drain();

		write_reg(ADDR_THRESHOLD, 32'd32768);
		write_reg(ADDR_BLUE_GAIN, 32'd2621);
		hold_go = 1'b1;
		push_random_cells(30);
		drain();

		for (int ph = 0; ph < 5; ph++) begin
			write_reg(ADDR_THRESHOLD, ph[0] ? $urandom_range(0, 131071)
				: $urandom_range(10000, 60000));
			write_reg(ADDR_BLUE_GAIN, (ph == 2) ? 32'd65535 : $urandom_range(0, 65535));
			no_idle = (ph == 3);
			push_random_cells(18);
			drain();
		end

		$display("Sent %0d sub-pixels over several threshold and gain settings,", pix_sent);
		$display("checked %0d cells, %0d of them lit.", cells_seen, lit_cells_seen);
		if (errors == 0) begin
			$display("braille_cell_color_grader_test: clean");
		end else begin
			$display("braille_cell_color_grader_test: errors");
		end
		$finish;
	end
endmodule
